/* rtl/sit_pkg.sv */
// Package for the sorted interval table: sizes, operation and status codes,
// the entry layout and the controller state type. No dependencies.
`default_nettype none
package sit_pkg;
    localparam int Depth    = 256;
    localparam int IdxBits  = $clog2(Depth);
    localparam int CntBits  = IdxBits + 1;
    localparam int KeyBits  = 31;
    localparam int PosBits  = 8;

    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_REM_KEY = 3'd1;
    localparam logic [2:0] MODE_REM_POS = 3'd2;
    localparam logic [2:0] MODE_FIND    = 3'd3;
    localparam logic [2:0] MODE_FIRST   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRIMMED   = 3'd1;
    localparam logic [2:0] ST_OVL_PREV  = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_OVL_NEXT  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [CntBits-1:0] NoneIdx = CntBits'(Depth);

    typedef struct packed {
        logic [KeyBits-1:0] start;
        logic [KeyBits-1:0] len;
        logic [IdxBits-1:0] next;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_DEC, S_ALLOC, S_LINK, S_OUT
    } t_state;
endpackage
`default_nettype wire

/* rtl/sorted_interval_table.sv */
// Sorted interval table: up to 256 non-overlapping intervals kept as a linked
// list in ascending start order, with insert, remove, find and read-first.
// One request at a time: a new request is taken only once the previous result
// has moved into the output register; the linked-list walk through the entry
// memory sets the rate.
// Reset: synchronous, active low; the table reads empty right after reset,
// no clearing pass is needed.
`default_nettype none
module sorted_interval_table (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [71:0]          s_axis_tdata,  // key[30:0], block_size[61:31], position[69:62]
    input  wire  [2:0]           s_axis_tuser,  // mode[2:0]
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [71:0]          m_axis_tdata,  // found_start[30:0], found_size[61:31],
                                                // entry_count[70:62]
    output logic [2:0]           m_axis_tuser   // status[2:0]
);
    import sit_pkg::*;

    // Entry memory (start, length, link) and the free-slot stack.
    t_entry             r_mem [Depth];
    logic [IdxBits-1:0] r_free [Depth];
    t_entry             r_q;
    logic [IdxBits-1:0] r_fq;

    t_state r_state, n_state;

    // Request, held for the whole operation.
    logic [2:0]         r_mode;
    logic [KeyBits-1:0] r_key, r_bs;
    logic [PosBits-1:0] r_pos;

    // List bookkeeping.
    logic [CntBits-1:0] r_head, n_head;
    logic [CntBits-1:0] r_held, n_held;
    logic [CntBits-1:0] r_fsp, n_fsp;   // free stack depth
    logic [CntBits-1:0] r_hwm, n_hwm;   // slots ever handed out

    // Walk registers.
    logic [CntBits-1:0] r_prev, n_prev, r_cur, n_cur, r_n, n_n;
    logic [KeyBits-1:0] r_ps, n_ps, r_pl, n_pl;
    logic [KeyBits-1:0] r_cs, n_cs, r_cl, n_cl;
    logic [IdxBits-1:0] r_cn, n_cn, r_slot, n_slot;
    logic [KeyBits-1:0] r_len, n_len;

    // Result being built, then the output register.
    logic [2:0]         r_st, n_st;
    logic [KeyBits-1:0] r_fs, n_fs, r_fz, n_fz;
    logic               r_ov, n_ov;
    logic [2:0]         r_ost, n_ost;
    logic [KeyBits-1:0] r_ofs, n_ofs, r_ofz, n_ofz;
    logic [CntBits-1:0] r_ocnt, n_ocnt;

    // Memory port controls.
    logic               mem_we, free_we;
    logic [IdxBits-1:0] mem_wa, mem_ra, free_wa, free_ra;
    t_entry             mem_wd;

    logic               s_acc, cur_v, prev_v, go_on, trimmed;
    logic [KeyBits:0]   prev_end, new_end;
    logic [IdxBits-1:0] alloc_slot;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tdata  = {1'b0, r_ocnt, r_ofz, r_ofs};

    assign cur_v    = (r_cur != NoneIdx);
    assign prev_v   = (r_prev != NoneIdx);
    assign prev_end = {1'b0, r_ps} + {1'b0, r_pl};
    assign new_end  = {1'b0, r_key} + {1'b0, r_bs};
    assign trimmed  = cur_v && (new_end > {1'b0, r_cs});
    assign alloc_slot = (r_fsp != '0) ? r_fq : r_hwm[IdxBits-1:0];

    // Walk step test: by rank for remove by position, by start otherwise;
    // remove by key zero and read first never advance past the head.
    always_comb begin
        case (r_mode)
            MODE_REM_POS: go_on = (r_n < {1'b0, r_pos});
            MODE_REM_KEY: go_on = (r_key != '0) && (r_q.start < r_key);
            MODE_FIRST:   go_on = 1'b0;
            default:      go_on = (r_q.start < r_key);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[mem_ra];
        if (free_we) begin
            r_free[free_wa] <= r_cur[IdxBits-1:0];
        end
        r_fq <= r_free[free_ra];
    end

    always_comb begin
        n_state = r_state;
        n_head = r_head; n_held = r_held; n_fsp = r_fsp; n_hwm = r_hwm;
        n_prev = r_prev; n_cur = r_cur; n_n = r_n;
        n_ps = r_ps; n_pl = r_pl; n_cs = r_cs; n_cl = r_cl; n_cn = r_cn;
        n_slot = r_slot; n_len = r_len;
        n_st = r_st; n_fs = r_fs; n_fz = r_fz;
        n_ov = r_ov; n_ost = r_ost; n_ofs = r_ofs; n_ofz = r_ofz; n_ocnt = r_ocnt;
        mem_we = 1'b0; mem_wa = r_prev[IdxBits-1:0]; mem_wd = '0;
        mem_ra = r_cur[IdxBits-1:0];
        free_we = 1'b0; free_wa = r_fsp[IdxBits-1:0];
        free_ra = IdxBits'(r_fsp - 1'b1);

        if (m_axis_tvalid && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    // Start every walk at the head with no predecessor.
                    n_prev = NoneIdx;
                    n_cur  = r_head;
                    n_n    = '0;
                    n_st   = ST_NOT_FOUND;
                    n_fs   = '0;
                    n_fz   = '0;
                    if (s_axis_tuser > MODE_FIRST) begin
                        n_state = S_OUT;
                    end else if (s_axis_tuser == MODE_REM_POS &&
                                 {1'b0, s_axis_tdata[69:62]} >= r_held) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // Stop once every held entry is passed.
                if (r_n >= r_held) begin
                    n_cur   = NoneIdx;
                    n_state = S_DEC;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (go_on) begin
                    n_prev  = r_cur;
                    n_ps    = r_q.start;
                    n_pl    = r_q.len;
                    n_cur   = {1'b0, r_q.next};
                    n_n     = r_n + 1'b1;
                    n_state = S_RD;
                end else begin
                    n_cs    = r_q.start;
                    n_cl    = r_q.len;
                    n_cn    = r_q.next;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                case (r_mode)
                    MODE_INSERT: begin
                        if (cur_v && r_cs == r_key) begin
                            n_st = ST_DUP;
                        end else if (prev_v && {1'b0, r_key} < prev_end) begin
                            n_st = ST_OVL_PREV;
                        end else if (trimmed && r_key == '0) begin
                            n_st = ST_OVL_NEXT;
                        end else if (r_held >= CntBits'(Depth)) begin
                            n_st = ST_FULL;
                        end else begin
                            n_len   = trimmed ? (r_cs - r_key) : r_bs;
                            n_st    = trimmed ? ST_TRIMMED : ST_OK;
                            n_fs    = r_key;
                            n_fz    = trimmed ? (r_cs - r_key) : r_bs;
                            n_state = S_ALLOC;  // free stack top is read now
                        end
                    end
                    MODE_REM_KEY, MODE_REM_POS: begin
                        if (cur_v && (r_mode == MODE_REM_POS || r_key == '0 ||
                                      r_cs == r_key)) begin
                            n_st = ST_OK;
                            n_fs = r_cs;
                            n_fz = r_cl;
                            // Unlink: bypass the entry, return its slot.
                            if (prev_v) begin
                                mem_we = 1'b1;
                                mem_wd = '{start: r_ps, len: r_pl, next: r_cn};
                            end else begin
                                n_head = {1'b0, r_cn};
                            end
                            free_we = 1'b1;
                            n_fsp   = r_fsp + 1'b1;
                            n_held  = r_held - 1'b1;
                            if (r_held == CntBits'(1)) begin
                                n_head = NoneIdx;
                            end
                        end
                    end
                    MODE_FIND: begin
                        if (cur_v) begin
                            n_st = ST_OK;
                            if (r_cs == r_key || !prev_v) begin
                                n_fs = r_cs;
                                n_fz = r_cl;
                            end else begin
                                n_fs = r_ps;
                                n_fz = r_pl;
                            end
                        end else if (prev_v && prev_end > {1'b0, r_key}) begin
                            n_st = ST_OK;
                            n_fs = r_ps;
                            n_fz = r_pl;
                        end
                    end
                    default: begin
                        if (cur_v) begin
                            n_st = ST_OK;
                            n_fs = r_cs;
                            n_fz = r_cl;
                        end
                    end
                endcase
            end
            S_ALLOC: begin
                // Write the new entry ahead of the located one.
                mem_we = 1'b1;
                mem_wa = alloc_slot;
                mem_wd = '{start: r_key, len: r_len, next: r_cur[IdxBits-1:0]};
                n_slot = alloc_slot;
                n_held = r_held + 1'b1;
                if (r_fsp != '0) begin
                    n_fsp = r_fsp - 1'b1;
                end else begin
                    n_hwm = r_hwm + 1'b1;
                end
                if (prev_v) begin
                    n_state = S_LINK;
                end else begin
                    n_head  = {1'b0, alloc_slot};
                    n_state = S_OUT;
                end
            end
            S_LINK: begin
                mem_we  = 1'b1;
                mem_wd  = '{start: r_ps, len: r_pl, next: r_slot};
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free.
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_ost   = r_st;
                    n_ofs   = r_fs;
                    n_ofz   = r_fz;
                    n_ocnt  = r_held;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NoneIdx;
            r_held  <= '0;
            r_fsp   <= '0;
            r_hwm   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_held  <= n_held;
            r_fsp   <= n_fsp;
            r_hwm   <= n_hwm;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode <= s_axis_tuser;
            r_key  <= s_axis_tdata[30:0];
            r_bs   <= s_axis_tdata[61:31];
            r_pos  <= s_axis_tdata[69:62];
        end
        r_prev <= n_prev; r_cur <= n_cur; r_n <= n_n;
        r_ps <= n_ps; r_pl <= n_pl; r_cs <= n_cs; r_cl <= n_cl; r_cn <= n_cn;
        r_slot <= n_slot; r_len <= n_len;
        r_st <= n_st; r_fs <= n_fs; r_fz <= n_fz;
        r_ost <= n_ost; r_ofs <= n_ofs; r_ofz <= n_ofz; r_ocnt <= n_ocnt;
    end
endmodule
`default_nettype wire

/* rtl/sit_checker.sv */
// Port-level checks for the sorted interval table, bound to the top level.
// Depends on sorted_interval_table port names only.
`default_nettype none
module sit_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [71:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:62] <= 9'd256)
        else $error("entry count above table depth");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser >= 3'd2 |-> m_axis_tdata[61:0] == 62'd0)
        else $error("failed request reports an interval");
endmodule

bind sorted_interval_table sit_checker u_sit_checker (.*);
`default_nettype wire
